### hdl/hdst_pkg.sv
// Shared types, constants and codes for the half-duplex line turnaround controller.
package hdst_pkg;

	localparam int BUF_BYTES = 512;
	localparam int BUF_AW    = $clog2(BUF_BYTES);
	localparam int POS_W     = $clog2(BUF_BYTES + 1);

	localparam logic [3:0] CMD_TICK     = 4'd0;
	localparam logic [3:0] CMD_LSTAT    = 4'd1;
	localparam logic [3:0] CMD_RX_WORD  = 4'd2;
	localparam logic [3:0] CMD_WSTART   = 4'd3;
	localparam logic [3:0] CMD_LOAD     = 4'd4;
	localparam logic [3:0] CMD_CTS      = 4'd5;
	localparam logic [3:0] CMD_TX_DONE  = 4'd6;
	localparam logic [3:0] CMD_TX_ERR   = 4'd7;
	localparam logic [3:0] CMD_READ     = 4'd8;

	localparam logic [1:0] MODE_RX   = 2'd0;
	localparam logic [1:0] MODE_TX   = 2'd1;
	localparam logic [1:0] MODE_PREP = 2'd2;

	localparam logic [15:0] RXC_TURN = 16'o562;
	localparam logic [15:0] RXC_RECV = 16'o162;
	localparam logic [15:0] RXC_PREP = 16'o46;
	localparam logic [15:0] TXC_HALF = 16'o10;
	localparam logic [15:0] TXC_SEND = 16'o170;

	localparam logic [7:0] TICKS_RESET = 8'd10;
	localparam logic [1:0] REG_TURNAROUND = 2'd0;

	typedef enum logic [3:0] {
		OP_NONE,
		OP_TICK,
		OP_LSTAT,
		OP_RX_WORD,
		OP_WSTART,
		OP_LOAD,
		OP_CTS,
		OP_TX_DONE,
		OP_TX_ERR,
		OP_READ
	} op_t;

	typedef struct packed {
		logic [3:0]  command;
		logic        carrier_present;
		logic [15:0] rx_word;
		logic [15:0] length;
		logic [8:0]  byte_index;
		logic [7:0]  byte_value;
	} in_req_t;

	typedef struct packed {
		logic        tx_valid;
		logic [7:0]  tx_byte;
		logic [15:0] rx_control;
		logic [15:0] tx_control;
		logic [1:0]  line_mode;
		logic [9:0]  received_count;
		logic [7:0]  read_data;
		logic        wake;
		logic        turned;
	} out_rsp_t;

	// A request after classification, as it waits in the queue.
	typedef struct packed {
		op_t               op;
		logic              carrier;
		logic [POS_W-1:0]  send_len;
		logic [BUF_AW-1:0] addr;
		logic              addr_ok;
		logic [7:0]        wdata;
	} op_item_t;

	typedef struct packed {
		logic full;
		logic not_empty;
	} q_status_t;

endpackage

### hdl/half_duplex_sync_line_turnaround.sv
// Top level of the half-duplex synchronous line turnaround controller.
// Each request on the cmd channel carries one line event (timer tick, line
// status, received word, write start, buffer load, clear to send, transmit
// done, transmit error or buffer read) and produces exactly one result on the
// res channel, in order. The block sustains one request per clock cycle while
// the queue has room: a request accepted at one edge is classified and written
// into a two-entry queue, executed against the line state and the 512-byte
// single-port buffer at the next edge at the earliest, and its result is
// offered from the following cycle. The queue registers every request, and
// the result register is there for the buffer's registered read data; it
// holds a finished result while the next requests keep entering the queue, and
// cmd ready drops only when the queue is full. The buffer has no reset, and
// reading a byte that was never written returns an arbitrary value. The one
// configuration register, turnaround_ticks (byte address 0, reset 10), is the
// timer reload value; write it only while no request is in flight. A reload
// of zero stops the timer.
module half_duplex_sync_line_turnaround (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cmd_valid,
	output logic               cmd_ready,
	input  hdst_pkg::in_req_t  cmd,
	output logic               res_valid,
	input  logic               res_ready,
	output hdst_pkg::out_rsp_t res,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [1:0]         paddr,
	input  logic [31:0]        pwdata,
	output logic [31:0]        prdata,
	output logic               pready
);

	logic [7:0]          ticks_q;
	hdst_pkg::op_item_t  front_item;
	hdst_pkg::op_item_t  head_item;
	hdst_pkg::q_status_t q_status;
	logic                push;
	logic                pop;

	// Configuration: the register updates on the access phase of a write.
	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ticks_q <= hdst_pkg::TICKS_RESET;
		end else if (psel && penable && pwrite && paddr == hdst_pkg::REG_TURNAROUND) begin
			ticks_q <= pwdata[7:0];
		end
	end

	// Reads of any other address return zero.
	assign prdata = (paddr == hdst_pkg::REG_TURNAROUND) ? {24'd0, ticks_q} : 32'd0;

	// A request is accepted whenever the queue has room.
	assign cmd_ready = !q_status.full;
	assign push      = cmd_valid && cmd_ready;

	hdst_front u_front (
		.req  (cmd),
		.item (front_item)
	);

	hdst_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_item (front_item),
		.pop       (pop),
		.head      (head_item),
		.status    (q_status)
	);

	// The back end owns the line state, the buffer and the result register.
	hdst_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.reload     (ticks_q),
		.item_valid (q_status.not_empty),
		.item       (head_item),
		.item_pop   (pop),
		.res_valid  (res_valid),
		.res_ready  (res_ready),
		.res        (res)
	);

endmodule

### hdl/hdst_front.sv
// Front end: classifies an incoming request into an operation for the back end.
module hdst_front (
	input  hdst_pkg::in_req_t  req,
	output hdst_pkg::op_item_t item
);

	always_comb begin
		item.op       = hdst_pkg::OP_NONE;
		item.carrier  = req.carrier_present;
		item.addr     = hdst_pkg::BUF_AW'(req.byte_index);
		item.addr_ok  = (32'(req.byte_index) < hdst_pkg::BUF_BYTES);
		if (32'(req.length) > hdst_pkg::BUF_BYTES) begin
			item.send_len = hdst_pkg::POS_W'(hdst_pkg::BUF_BYTES);
		end else begin
			item.send_len = hdst_pkg::POS_W'(req.length);
		end
		item.wdata = req.byte_value;
		case (req.command)
			hdst_pkg::CMD_TICK: begin
				item.op = hdst_pkg::OP_TICK;
			end
			hdst_pkg::CMD_LSTAT: begin
				item.op = hdst_pkg::OP_LSTAT;
			end
			hdst_pkg::CMD_RX_WORD: begin
				item.op    = hdst_pkg::OP_RX_WORD;
				// Seven data bits, with the top bit of the word as bit seven.
				item.wdata = {req.rx_word[15], req.rx_word[6:0]};
			end
			hdst_pkg::CMD_WSTART: begin
				// A zero-length write start has no effect at all.
				item.op = (req.length != 16'd0) ? hdst_pkg::OP_WSTART : hdst_pkg::OP_NONE;
			end
			hdst_pkg::CMD_LOAD: begin
				item.op = hdst_pkg::OP_LOAD;
			end
			hdst_pkg::CMD_CTS: begin
				item.op = hdst_pkg::OP_CTS;
			end
			hdst_pkg::CMD_TX_DONE: begin
				item.op = hdst_pkg::OP_TX_DONE;
			end
			hdst_pkg::CMD_TX_ERR: begin
				item.op = hdst_pkg::OP_TX_ERR;
			end
			hdst_pkg::CMD_READ: begin
				item.op = hdst_pkg::OP_READ;
			end
			default: begin
				item.op = hdst_pkg::OP_NONE;
			end
		endcase
	end

endmodule

### hdl/hdst_queue.sv
// Two-entry queue between the front end and the back end.
module hdst_queue (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	input  hdst_pkg::op_item_t  push_item,
	input  logic                pop,
	output hdst_pkg::op_item_t  head,
	output hdst_pkg::q_status_t status
);

	hdst_pkg::op_item_t entry_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] count_q;

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + 2'd1;
				2'b01:   count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end

	assign head             = entry_q[rd_ptr_q];
	assign status.full      = (count_q == 2'd2);
	assign status.not_empty = (count_q != 2'd0);

endmodule

### hdl/hdst_back.sv
// Back end: line state, byte buffer and result register.
module hdst_back (
	input  logic               clk,
	input  logic               arst_n,
	input  logic [7:0]         reload,
	input  logic               item_valid,
	input  hdst_pkg::op_item_t item,
	output logic               item_pop,
	output logic               res_valid,
	input  logic               res_ready,
	output hdst_pkg::out_rsp_t res
);

	logic [7:0] line_buffer [hdst_pkg::BUF_BYTES];

	logic [1:0]                 mode_q, mode_d;
	logic [7:0]                 timer_q, timer_d;
	logic [hdst_pkg::POS_W-1:0] pos_q, pos_d;
	logic [hdst_pkg::POS_W-1:0] left_q, left_d;
	logic [15:0]                rxc_q, rxc_d;
	logic [15:0]                txc_q, txc_d;

	logic                        exec;
	logic                        turn, send, wake;
	logic                        mem_we, mem_re, use_tx_mem, use_rd_mem;
	logic [hdst_pkg::BUF_AW-1:0] mem_addr;
	logic                        pos_room;

	logic       valid_q;
	logic       txv_s2, txmem_s2, rdmem_s2, wake_s2, turned_s2;
	logic [7:0] rdata_s2;

	// Execute only when the result slot is empty or being emptied, so the
	// result register and the line state always describe the same request.
	assign exec     = item_valid && (!valid_q || res_ready);
	assign item_pop = exec;
	assign pos_room = (32'(pos_q) < hdst_pkg::BUF_BYTES);

	always_comb begin
		mode_d     = mode_q;
		timer_d    = timer_q;
		pos_d      = pos_q;
		left_d     = left_q;
		rxc_d      = rxc_q;
		txc_d      = txc_q;
		turn       = 1'b0;
		send       = 1'b0;
		wake       = 1'b0;
		mem_we     = 1'b0;
		mem_re     = 1'b0;
		use_tx_mem = 1'b0;
		use_rd_mem = 1'b0;
		mem_addr   = hdst_pkg::BUF_AW'(pos_q);
		case (item.op)
			hdst_pkg::OP_TICK: begin
				if (timer_q == 8'd1) begin
					turn = 1'b1;
				end else if (timer_q != 8'd0) begin
					timer_d = timer_q - 8'd1;
				end
			end
			hdst_pkg::OP_LSTAT: begin
				if (!item.carrier && mode_q == hdst_pkg::MODE_RX) begin
					turn = 1'b1;
				end else begin
					wake = 1'b1;
				end
			end
			hdst_pkg::OP_RX_WORD: begin
				rxc_d = hdst_pkg::RXC_RECV;
				if (pos_room) begin
					mem_we = 1'b1;
					pos_d  = pos_q + 1'b1;
				end
			end
			hdst_pkg::OP_WSTART: begin
				if (mode_q == hdst_pkg::MODE_RX) begin
					pos_d   = '0;
					mode_d  = hdst_pkg::MODE_PREP;
					rxc_d   = hdst_pkg::RXC_PREP;
					left_d  = item.send_len;
					timer_d = reload;
				end
			end
			hdst_pkg::OP_LOAD: begin
				mem_addr = item.addr;
				mem_we   = item.addr_ok;
			end
			hdst_pkg::OP_CTS: begin
				if (mode_q != hdst_pkg::MODE_TX) begin
					mode_d = hdst_pkg::MODE_TX;
					txc_d  = hdst_pkg::TXC_SEND;
					send   = 1'b1;
				end
			end
			hdst_pkg::OP_TX_DONE: begin
				send = (mode_q == hdst_pkg::MODE_TX);
			end
			hdst_pkg::OP_TX_ERR: begin
				turn = (mode_q == hdst_pkg::MODE_TX);
			end
			hdst_pkg::OP_READ: begin
				mem_addr   = item.addr;
				mem_re     = item.addr_ok;
				use_rd_mem = item.addr_ok;
			end
			default: begin
				mode_d = mode_q;
			end
		endcase

		// One byte goes out per send step; with nothing left the line turns.
		if (send) begin
			timer_d = reload;
			if (left_q != '0) begin
				left_d = left_q - 1'b1;
				if (pos_room) begin
					mem_re     = 1'b1;
					use_tx_mem = 1'b1;
					pos_d      = pos_q + 1'b1;
				end
			end else begin
				turn = 1'b1;
			end
		end

		if (turn) begin
			if (mode_d != hdst_pkg::MODE_RX) begin
				mode_d  = hdst_pkg::MODE_RX;
				timer_d = reload;
				pos_d   = '0;
			end
			txc_d = hdst_pkg::TXC_HALF;
			rxc_d = hdst_pkg::RXC_TURN;
			wake  = 1'b1;
			// Timer expiry leaves the timer parked at one.
			if (item.op == hdst_pkg::OP_TICK) begin
				timer_d = 8'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (exec && mem_we) begin
			line_buffer[mem_addr] <= item.wdata;
		end
		if (exec && mem_re) begin
			rdata_s2 <= line_buffer[mem_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q    <= hdst_pkg::MODE_RX;
			timer_q   <= 8'd0;
			pos_q     <= '0;
			left_q    <= '0;
			rxc_q     <= 16'd0;
			txc_q     <= 16'd0;
			valid_q   <= 1'b0;
			txv_s2    <= 1'b0;
			txmem_s2  <= 1'b0;
			rdmem_s2  <= 1'b0;
			wake_s2   <= 1'b0;
			turned_s2 <= 1'b0;
		end else begin
			if (exec) begin
				mode_q    <= mode_d;
				timer_q   <= timer_d;
				pos_q     <= pos_d;
				left_q    <= left_d;
				rxc_q     <= rxc_d;
				txc_q     <= txc_d;
				valid_q   <= 1'b1;
				txv_s2    <= send && (left_q != '0);
				txmem_s2  <= use_tx_mem;
				rdmem_s2  <= use_rd_mem;
				wake_s2   <= wake;
				turned_s2 <= turn;
			end else if (res_ready) begin
				valid_q <= 1'b0;
			end
		end
	end

	assign res_valid          = valid_q;
	assign res.tx_valid       = txv_s2;
	assign res.tx_byte        = txmem_s2 ? rdata_s2 : 8'd0;
	assign res.rx_control     = rxc_q;
	assign res.tx_control     = txc_q;
	assign res.line_mode      = mode_q;
	assign res.received_count = 10'(pos_q);
	assign res.read_data      = rdmem_s2 ? rdata_s2 : 8'd0;
	assign res.wake           = wake_s2;
	assign res.turned         = turned_s2;

endmodule

### test/line_tracker_pkg.sv
// Expected-result tracker for the half-duplex line turnaround controller testbench.
package line_tracker_pkg;

	import hdst_pkg::*;

	class line_tracker;
		logic [7:0]  ticks;
		logic [1:0]  mode;
		logic [7:0]  timer;
		logic [9:0]  position;
		logic [9:0]  send_left;
		logic [7:0]  line_buf [BUF_BYTES];
		bit          written [BUF_BYTES];
		logic [15:0] rx_ctrl;
		logic [15:0] tx_ctrl;
		out_rsp_t    pending [$];
		int          mismatches;

		function new();
			ticks = TICKS_RESET;
			mode = MODE_RX;
			timer = '0;
			position = '0;
			send_left = '0;
			rx_ctrl = '0;
			tx_ctrl = '0;
			mismatches = 0;
		endfunction

		task report(string what, logic [15:0] got, logic [15:0] want);
			mismatches++;
			$display("mismatch in %s: got %0h, expected %0h", what, got, want);
		endtask

		function void turn_line(inout out_rsp_t r);
			if (mode != MODE_RX) begin
				mode = MODE_RX;
				timer = ticks;
				position = '0;
			end
			tx_ctrl = TXC_HALF;
			rx_ctrl = RXC_TURN;
			r.wake = 1'b1;
			r.turned = 1'b1;
		endfunction

		function void send_step(inout out_rsp_t r);
			timer = ticks;
			if (send_left != 0) begin
				send_left--;
				r.tx_valid = 1'b1;
				// Past the end of the buffer the byte handed out is zero.
				if (position < BUF_BYTES) begin
					r.tx_byte = line_buf[position[8:0]];
					position++;
				end
			end else begin
				turn_line(r);
			end
		endfunction

		// Steers a request away from reading a buffer byte that was never written, by a read or by a send.
		function void keep_reads_defined(inout in_req_t q);
			if (q.command == CMD_READ && !written[q.byte_index]) begin
				for (int i = 1; i < BUF_BYTES && !written[q.byte_index]; i++)
					if (written[(q.byte_index + i) % BUF_BYTES])
						q.byte_index = 9'((q.byte_index + i) % BUF_BYTES);
				if (!written[q.byte_index])
					q.command = CMD_LOAD;
			end
			if (((q.command == CMD_CTS && mode != MODE_TX) ||
			     (q.command == CMD_TX_DONE && mode == MODE_TX)) &&
			    send_left != 0 && position < BUF_BYTES && !written[position[8:0]]) begin
				q.command = CMD_LOAD;
				q.byte_index = position[8:0];
			end
		endfunction

		function void note_request(in_req_t q);
			out_rsp_t r;
			r = '0;
			case (q.command)
				CMD_TICK: begin
					if (timer != 0) begin
						timer--;
						if (timer == 0) begin
							turn_line(r);
							timer = 8'd1;
						end
					end
				end
				CMD_LSTAT: begin
					if (!q.carrier_present && mode == MODE_RX)
						turn_line(r);
					else
						r.wake = 1'b1;
				end
				CMD_RX_WORD: begin
					rx_ctrl = RXC_RECV;
					if (position < BUF_BYTES) begin
						line_buf[position[8:0]] = {q.rx_word[15], q.rx_word[6:0]};
						written[position[8:0]] = 1'b1;
						position++;
					end
				end
				CMD_WSTART: begin
					if (q.length != 0 && mode == MODE_RX) begin
						position = '0;
						mode = MODE_PREP;
						rx_ctrl = RXC_PREP;
						send_left = (q.length > BUF_BYTES) ? 10'(BUF_BYTES) : q.length[9:0];
						timer = ticks;
					end
				end
				CMD_LOAD: begin
					line_buf[q.byte_index] = q.byte_value;
					written[q.byte_index] = 1'b1;
				end
				CMD_CTS: begin
					if (mode != MODE_TX) begin
						mode = MODE_TX;
						tx_ctrl = TXC_SEND;
						send_step(r);
					end
				end
				CMD_TX_DONE: begin
					if (mode == MODE_TX)
						send_step(r);
				end
				CMD_TX_ERR: begin
					if (mode == MODE_TX)
						turn_line(r);
				end
				CMD_READ: begin
					r.read_data = line_buf[q.byte_index];
				end
				default: begin
				end
			endcase
			r.rx_control = rx_ctrl;
			r.tx_control = tx_ctrl;
			r.line_mode = mode;
			r.received_count = position;
			pending.push_back(r);
		endfunction

		task check_response(out_rsp_t got);
			out_rsp_t want;
			if (pending.size() == 0) begin
				report("result with no request pending", 16'd1, 16'd0);
				return;
			end
			want = pending.pop_front();
			if (got.tx_valid !== want.tx_valid)
				report("tx_valid", 16'(got.tx_valid), 16'(want.tx_valid));
			if (got.tx_byte !== want.tx_byte)
				report("tx_byte", 16'(got.tx_byte), 16'(want.tx_byte));
			if (got.rx_control !== want.rx_control)
				report("rx_control", got.rx_control, want.rx_control);
			if (got.tx_control !== want.tx_control)
				report("tx_control", got.tx_control, want.tx_control);
			if (got.line_mode !== want.line_mode)
				report("line_mode", 16'(got.line_mode), 16'(want.line_mode));
			if (got.received_count !== want.received_count)
				report("received_count", 16'(got.received_count), 16'(want.received_count));
			if (got.read_data !== want.read_data)
				report("read_data", 16'(got.read_data), 16'(want.read_data));
			if (got.wake !== want.wake)
				report("wake", 16'(got.wake), 16'(want.wake));
			if (got.turned !== want.turned)
				report("turned", 16'(got.turned), 16'(want.turned));
		endtask
	endclass

endpackage

### test/half_duplex_sync_line_turnaround_test.sv
// Self-checking testbench for the half-duplex synchronous line turnaround controller.
module half_duplex_sync_line_turnaround_test;

	import hdst_pkg::*;
	import line_tracker_pkg::*;

	// The one register lives at byte address 4 * its index.
	localparam logic [1:0] TURN_ADDR = 2'(4 * REG_TURNAROUND);
	// A long receiver hold-off, well beyond what the two-entry queue can absorb.
	localparam int HOLD_CYCLES = 300;
	// Cycles without any handshake before the run is declared hung. The slowest
	// correct stretch is the receiver hold-off plus a few stall runs, so this
	// leaves a wide margin.
	localparam int QUIET_LIMIT = 4000;

	logic     clk = 1'b0;
	logic     arst_n = 1'b0;
	logic     cmd_valid = 1'b0;
	logic     cmd_ready;
	in_req_t  cmd = '0;
	logic     res_valid;
	logic     res_ready = 1'b0;
	out_rsp_t res;
	logic     psel = 1'b0;
	logic     penable = 1'b0;
	logic     pwrite = 1'b0;
	logic [1:0]  paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic        pready;

	line_tracker board = new();

	int tx_idle_pct = 0;
	int rx_stall_pct = 0;
	int requests_sent = 0;
	int quiet_cycles = 0;
	int hold_left = 0;
	bit hold_toggle = 1'b0;
	bit hold_seen = 1'b0;

	half_duplex_sync_line_turnaround dut (
		.clk(clk),
		.arst_n(arst_n),
		.cmd_valid(cmd_valid),
		.cmd_ready(cmd_ready),
		.cmd(cmd),
		.res_valid(res_valid),
		.res_ready(res_ready),
		.res(res),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	// Result side. Every accepted result is checked against the oldest
	// expectation. The ready line stalls at random, and when the stimulus flips
	// hold_toggle the receiver holds off for a long stretch that it counts here.
	always @(posedge clk) begin
		if (arst_n && res_valid && res_ready)
			board.check_response(res);
		if (hold_toggle != hold_seen) begin
			hold_seen <= hold_toggle;
			hold_left <= HOLD_CYCLES;
			res_ready <= 1'b0;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
			res_ready <= 1'b0;
		end else begin
			res_ready <= ($urandom_range(99) >= rx_stall_pct);
		end
	end

	// Watchdog: a run that stops moving for too long has hung.
	always @(posedge clk) begin
		if (!arst_n || (cmd_valid && cmd_ready) || (res_valid && res_ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("timeout after %0d cycles without a handshake", quiet_cycles);
			$display("simulation failed");
			$finish;
		end
	end

	// Every field gets random content, so each bit of each field is exercised
	// whatever the command; the length is mostly small so transfers stay short.
	function automatic in_req_t random_fields(logic [3:0] c);
		in_req_t q;
		q.command = c;
		q.carrier_present = 1'($urandom);
		q.rx_word = 16'($urandom);
		q.length = ($urandom_range(3) == 0) ? 16'($urandom) : 16'($urandom_range(8));
		q.byte_index = 9'($urandom);
		q.byte_value = 8'($urandom);
		return q;
	endfunction

	function automatic logic [3:0] pick_command();
		int r;
		r = $urandom_range(99);
		if (r < 14) return CMD_TICK;
		if (r < 24) return CMD_LSTAT;
		if (r < 40) return CMD_RX_WORD;
		if (r < 50) return CMD_WSTART;
		if (r < 62) return CMD_LOAD;
		if (r < 70) return CMD_CTS;
		if (r < 80) return CMD_TX_DONE;
		if (r < 86) return CMD_TX_ERR;
		if (r < 95) return CMD_READ;
		// Codes above the last defined command must change nothing.
		return 4'($urandom_range(15, CMD_READ + 1));
	endfunction

	// Offers one request and returns at the edge where it is accepted. The
	// request is first adjusted so it never reads an unwritten buffer byte, and
	// it is noted for prediction at acceptance, in this same process, so the
	// next request is generated from up-to-date line state.
	task automatic send_request(input in_req_t q);
		board.keep_reads_defined(q);
		if ($urandom_range(99) < tx_idle_pct) begin
			cmd_valid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < tx_idle_pct);
		end
		cmd_valid <= 1'b1;
		cmd <= q;
		do @(posedge clk); while (!cmd_ready);
		board.note_request(q);
		requests_sent++;
	endtask

	// Stops offering requests until every expected result has come back.
	task automatic wait_drained();
		cmd_valid <= 1'b0;
		while (board.pending.size() != 0)
			@(posedge clk);
	endtask

	// Brings the line back to receive mode so that a write start takes effect.
	task automatic go_receive();
		while (board.mode != MODE_RX) begin
			if (board.mode == MODE_TX)
				send_request(random_fields(CMD_TX_ERR));
			else
				send_request(random_fields(CMD_CTS));
		end
	endtask

	// A well-formed transmission: fill the buffer, start the write, get clear
	// to send and keep acknowledging bytes until the line turns around. Now and
	// then a tick, a received word or a transmit error lands in the middle.
	task automatic send_frame(input int n);
		in_req_t q;
		go_receive();
		for (int i = 0; i < n; i++) begin
			q = random_fields(CMD_LOAD);
			q.byte_index = 9'(i);
			send_request(q);
		end
		q = random_fields(CMD_WSTART);
		q.length = 16'(n);
		send_request(q);
		if ($urandom_range(3) == 0)
			send_request(random_fields(CMD_LSTAT));
		send_request(random_fields(CMD_CTS));
		while (board.mode == MODE_TX) begin
			case ($urandom_range(19))
				0: send_request(random_fields(CMD_TX_ERR));
				1: send_request(random_fields(CMD_TICK));
				2: send_request(random_fields(CMD_RX_WORD));
				default: send_request(random_fields(CMD_TX_DONE));
			endcase
		end
	endtask

	// Half the rounds are transmissions with random content, the rest runs of ticks and
	// bursts of arbitrary commands.
	task automatic run_random(input int count);
		int stop_at;
		stop_at = requests_sent + count;
		while (requests_sent < stop_at) begin
			case ($urandom_range(9))
				0, 1, 2, 3, 4: begin
					if ($urandom_range(7) == 0)
						send_frame($urandom_range(40));
					else
						send_frame($urandom_range(8, 1));
				end
				5: begin
					repeat ($urandom_range(12, 1))
						send_request(random_fields(CMD_TICK));
				end
				default: begin
					repeat ($urandom_range(6, 1))
						send_request(random_fields(pick_command()));
				end
			endcase
		end
	endtask

	// Writes the turnaround reload over the register port and reads it back.
	// Only called with nothing in flight.
	task automatic set_turnaround(input logic [7:0] value);
		logic [31:0] readback;
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= TURN_ADDR;
		pwdata <= {24'b0, value};
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		board.ticks = value;
		pwrite <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		readback = prdata;
		psel <= 1'b0;
		penable <= 1'b0;
		if (readback[7:0] !== value)
			board.report("turnaround_ticks readback", 16'(readback[7:0]), 16'(value));
	endtask

	initial begin
		in_req_t q;

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// First the sender idles lightly while the receiver stalls often.
		tx_idle_pct = 19;
		rx_stall_pct = 71;

		// Directed part, run with the reset reload value. After reset the timer
		// is stopped, so the first tick must do nothing.
		send_request(random_fields(CMD_TICK));
		// Line status with carrier only wakes; without carrier in receive mode
		// the line turns around.
		q = random_fields(CMD_LSTAT);
		q.carrier_present = 1'b1;
		send_request(q);
		q.carrier_present = 1'b0;
		send_request(q);
		// Received words: the top bit becomes bit 7, bits 14 to 7 are dropped.
		q = random_fields(CMD_RX_WORD);
		q.rx_word = 16'hffff;
		send_request(q);
		q.rx_word = 16'h7f80;
		send_request(q);
		q.rx_word = 16'h0000;
		send_request(q);
		// Buffer loads and reads at both ends of the index range.
		q = random_fields(CMD_LOAD);
		q.byte_index = 9'h1ff;
		q.byte_value = 8'hff;
		send_request(q);
		q.byte_index = 9'h000;
		q.byte_value = 8'h00;
		send_request(q);
		q = random_fields(CMD_READ);
		q.byte_index = 9'h1ff;
		send_request(q);
		q.byte_index = 9'h000;
		send_request(q);
		// A zero-length write start is ignored; the largest length is clipped
		// to the buffer size; a second write start while preparing is ignored.
		q = random_fields(CMD_WSTART);
		q.length = 16'h0000;
		send_request(q);
		q.length = 16'hffff;
		send_request(q);
		q.length = 16'd3;
		send_request(q);
		// Losing carrier outside receive mode only wakes.
		q = random_fields(CMD_LSTAT);
		q.carrier_present = 1'b0;
		send_request(q);
		send_request(random_fields(CMD_TICK));
		// Clear to send starts sending; a second one while sending is ignored.
		send_request(random_fields(CMD_CTS));
		send_request(random_fields(CMD_CTS));
		send_request(random_fields(CMD_TX_DONE));
		send_request(random_fields(CMD_TX_DONE));
		send_request(random_fields(CMD_TX_ERR));
		// Transmitter events in receive mode are ignored, as are unknown codes.
		send_request(random_fields(CMD_TX_DONE));
		send_request(random_fields(CMD_TX_ERR));
		send_request(random_fields(4'(CMD_READ + 1)));
		send_request(random_fields('1));
		// Clear to send straight from receive mode, with bytes still left over.
		send_request(random_fields(CMD_CTS));
		send_request(random_fields(CMD_TX_ERR));

		// Fill the whole buffer while preparing so later bytes are dropped, then
		// send from a position past the end, which hands out zeros.
		go_receive();
		q = random_fields(CMD_WSTART);
		q.length = 16'(BUF_BYTES + $urandom_range(65535 - BUF_BYTES));
		send_request(q);
		repeat (BUF_BYTES + 8)
			send_request(random_fields(CMD_RX_WORD));
		send_request(random_fields(CMD_CTS));
		repeat (3)
			send_request(random_fields(CMD_TX_DONE));
		send_request(random_fields(CMD_TX_ERR));

		run_random(110);

		// The shortest reload makes every tick expire the timer.
		wait_drained();
		set_turnaround(8'd1);
		run_random(110);

		// Now the sender idles often and the receiver rarely stalls.
		tx_idle_pct = 71;
		rx_stall_pct = 19;
		wait_drained();
		set_turnaround(8'd255);
		run_random(80);
		// Long receiver hold-off while requests keep coming, so the queue fills
		// and the request side stalls.
		hold_toggle <= ~hold_toggle;
		run_random(110);

		// Finally neither side idles.
		tx_idle_pct = 0;
		rx_stall_pct = 0;
		wait_drained();
		// A zero reload stops the timer after any reload.
		set_turnaround(8'd0);
		run_random(80);
		wait_drained();
		set_turnaround(8'($urandom_range(254, 2)));
		run_random(100);

		wait_drained();
		repeat (20) @(posedge clk);
		if (board.mismatches == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule
